FILE: sv/hct_pkg.sv
// Shared types, codes and constants for the console timer block.
package hct_pkg;

    // Item kinds carried in s_tuser
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Register selects
    localparam logic [1:0] REG_DIV  = 2'd0;
    localparam logic [1:0] REG_TIMA = 2'd1;
    localparam logic [1:0] REG_TMA  = 2'd2;
    localparam logic [1:0] REG_TAC  = 2'd3;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // Cycles per prescaler step, cycles per divider step, unused TAC bits
    localparam logic [7:0] PRESCALE_STEP = 8'd16;
    localparam logic [8:0] DIV_STEP      = 9'd256;
    localparam logic [7:0] TAC_FIXED     = 8'hF8;

    // Result of one prescaler step
    typedef struct packed {
        logic [6:0] prescale;
        logic [7:0] counter;
        logic       overflow;
    } hct_step_t;

    // Prescaler threshold chosen by the frequency select
    function automatic logic [6:0] threshold_of(input logic [1:0] sel);
        logic [6:0] thr;
        case (sel)
            2'd0:    thr = 7'd64;
            2'd1:    thr = 7'd1;
            2'd2:    thr = 7'd4;
            default: thr = 7'd16;
        endcase
        return thr;
    endfunction

endpackage

FILE: sv/hct_step_unit.sv
// Shared prescaler/counter step unit: advances the prescaler by one step.
module hct_step_unit
    import hct_pkg::*;
(
    input  logic [6:0] prescale,
    input  logic [7:0] counter,
    input  logic [7:0] modulo,
    input  logic [1:0] freq_select,
    output hct_step_t  result
);

    logic [6:0] prescale_inc;
    logic [7:0] counter_inc;

    assign prescale_inc = prescale + 7'd1;
    assign counter_inc  = counter + 8'd1;

    // Threshold hit clears the prescaler and bumps the counter; wrap reloads
    always_comb
    begin
        result.prescale = prescale_inc;
        result.counter  = counter;
        result.overflow = 1'b0;
        if (prescale_inc >= threshold_of(freq_select))
        begin
            result.prescale = 7'd0;
            if (counter_inc == 8'd0)
            begin
                result.counter  = modulo;
                result.overflow = 1'b1;
            end
            else
            begin
                result.counter = counter_inc;
            end
        end
    end

endmodule

FILE: sv/handheld_console_timer_div_tima.sv
// Top level of the console timer: divider, counter, modulo and control.
//
// Usage
//   Items arrive on the s_ stream. s_tuser holds the kind (tick, register
//   read, register write); s_tdata holds cycles, speed multiplier, register
//   select and write data. Every item gives exactly one transfer on the
//   m_ stream carrying read data and the timer interrupt flag.
//   Reads, writes and ticks with the timer disabled post their result on
//   the cycle after the transfer in.
//   A tick with the timer enabled first adds the scaled cycle count, then
//   runs the prescaler steps it triggers (0 to 14) through the shared step
//   unit, one step per cycle, and then posts its result. The divider is
//   updated when the tick is taken in.
//   s_tready is low while a tick is being stepped and while a result is
//   held in the output register and not taken; a stalled receiver simply
//   holds the result and blocks new items.
//   Reset clears every timer register and empties the output register.
module handheld_console_timer_div_tima
    import hct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [4:0] cycles, [7:5] speed_multiplier, [9:8] reg_select,
    // [17:10] write_data, [23:18] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] read_data, [8] timer_irq, [15:9] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_STEP = 1'b1;

    logic       state_reg, state_next;
    logic [7:0] sub_reg, sub_next;
    logic [6:0] prescale_reg, prescale_next;
    logic [8:0] div_acc_reg, div_acc_next;
    logic [7:0] div_reg, div_next;
    logic [7:0] tima_reg, tima_next;
    logic [7:0] tma_reg, tma_next;
    logic       enable_reg, enable_next;
    logic [1:0] fsel_reg, fsel_next;
    logic       irq_acc_reg, irq_acc_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_rd_reg, m_rd_next;
    logic       m_irq_reg, m_irq_next;

    logic       s_xfer;
    logic [1:0] in_kind;
    logic [4:0] in_cycles;
    logic [2:0] in_mult;
    logic [1:0] in_sel;
    logic [7:0] in_wdata;
    logic [7:0] amount;
    logic [8:0] div_sum;
    hct_step_t  step_res;

    // Field unpacking
    assign in_kind   = s_tuser[1:0];
    assign in_cycles = s_tdata[4:0];
    assign in_mult   = s_tdata[7:5];
    assign in_sel    = s_tdata[9:8];
    assign in_wdata  = s_tdata[17:10];

    // Scaled cycle count, at most 31 * 7 = 217
    assign amount  = 8'({3'b000, in_cycles} * {5'b00000, in_mult});
    assign div_sum = div_acc_reg + {1'b0, amount};

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_xfer   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_irq_reg, m_rd_reg};

    // Shared prescaler step unit
    hct_step_unit u_step (
        .prescale    (prescale_reg),
        .counter     (tima_reg),
        .modulo      (tma_reg),
        .freq_select (fsel_reg),
        .result      (step_res)
    );

    // Sequencer and register updates
    always_comb
    begin
        state_next    = state_reg;
        sub_next      = sub_reg;
        prescale_next = prescale_reg;
        div_acc_next  = div_acc_reg;
        div_next      = div_reg;
        tima_next     = tima_reg;
        tma_next      = tma_reg;
        enable_next   = enable_reg;
        fsel_next     = fsel_reg;
        irq_acc_next  = irq_acc_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_rd_next     = m_rd_reg;
        m_irq_next    = m_irq_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    m_rd_next  = 8'd0;
                    m_irq_next = 1'b0;
                    case (in_kind)
                        KIND_TICK:
                        begin
                            // divider moves at most one step per tick
                            if (div_sum >= DIV_STEP)
                            begin
                                div_next     = div_reg + 8'd1;
                                div_acc_next = div_sum - DIV_STEP;
                            end
                            else
                            begin
                                div_acc_next = div_sum;
                            end
                            if (enable_reg)
                            begin
                                sub_next     = sub_reg + amount;
                                irq_acc_next = 1'b0;
                                state_next   = ST_STEP;
                            end
                            else
                            begin
                                m_valid_next = 1'b1;
                            end
                        end
                        KIND_READ:
                        begin
                            case (in_sel)
                                REG_DIV:  m_rd_next = div_reg;
                                REG_TIMA: m_rd_next = tima_reg;
                                REG_TMA:  m_rd_next = tma_reg;
                                default:
                                    m_rd_next = TAC_FIXED | {5'd0, enable_reg, fsel_reg};
                            endcase
                            m_valid_next = 1'b1;
                        end
                        KIND_WRITE:
                        begin
                            case (in_sel)
                                REG_DIV:  div_next  = 8'd0;
                                REG_TIMA: tima_next = in_wdata;
                                REG_TMA:  tma_next  = in_wdata;
                                default:
                                begin
                                    enable_next = in_wdata[2];
                                    fsel_next   = in_wdata[1:0];
                                end
                            endcase
                            m_valid_next = 1'b1;
                        end
                        default:
                        begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                // one prescaler step per cycle until less than one step's worth remains
                if (sub_reg >= PRESCALE_STEP)
                begin
                    sub_next      = sub_reg - PRESCALE_STEP;
                    prescale_next = step_res.prescale;
                    tima_next     = step_res.counter;
                    irq_acc_next  = irq_acc_reg | step_res.overflow;
                end
                else
                begin
                    m_valid_next = 1'b1;
                    m_irq_next   = irq_acc_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sub_reg      <= 8'd0;
            prescale_reg <= 7'd0;
            div_acc_reg  <= 9'd0;
            div_reg      <= 8'd0;
            tima_reg     <= 8'd0;
            tma_reg      <= 8'd0;
            enable_reg   <= 1'b0;
            fsel_reg     <= 2'd0;
            irq_acc_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sub_reg      <= sub_next;
            prescale_reg <= prescale_next;
            div_acc_reg  <= div_acc_next;
            div_reg      <= div_next;
            tima_reg     <= tima_next;
            tma_reg      <= tma_next;
            enable_reg   <= enable_next;
            fsel_reg     <= fsel_next;
            irq_acc_reg  <= irq_acc_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        m_rd_reg  <= m_rd_next;
        m_irq_reg <= m_irq_next;
    end

`ifndef SYNTHESIS
    // Between items fewer than one prescaler step's worth of cycles remain
    a_sub_small_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (sub_reg < PRESCALE_STEP))
        else $error("sub-cycle accumulator too large while idle");

    // Prescaler never passes the largest threshold
    a_prescale_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prescale_reg <= 7'd64)
        else $error("prescaler beyond largest threshold");

    // Stepping ends with a posted result
    a_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && sub_reg < PRESCALE_STEP)
            |=> (state_reg == ST_IDLE && m_valid_reg))
        else $error("tick finished without a result");

    // No new item is taken while a tick is being stepped
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> !s_tready)
        else $error("input ready while stepping");

    // An interrupt result never carries read data
    a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_irq_reg) |-> (m_rd_reg == 8'd0))
        else $error("interrupt result carries read data");
`endif

endmodule
